### rtl/core/timestamp_ordered_frame_pool_unit_macros.svh
// Assertion macros shared by the frame pool RTL.
`ifndef TIMESTAMP_ORDERED_FRAME_POOL_UNIT_MACROS_SVH
`define TIMESTAMP_ORDERED_FRAME_POOL_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TOFP_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define TOFP_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/tofp_pkg.sv
package tofp_pkg;

	// Pool geometry
	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W      = (CNT_W > 7) ? CNT_W : 7;
	localparam int TIME_W     = 64;
	localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOT_COUNT);

	// Opcodes
	localparam logic [1:0] OP_CLAIM    = 2'd0;
	localparam logic [1:0] OP_COMPLETE = 2'd1;
	localparam logic [1:0] OP_PICK     = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_END  = 2'd2;

	// Register map
	localparam int          PADDR_W         = 3;
	localparam logic        REG_MIN_READY   = 1'b0;
	localparam logic [6:0]  MIN_READY_RESET = 7'd10;

	// Slot number to the 6-bit result field (low bits, zero filled)
	function automatic logic [5:0] slot_field(input logic [SLOT_W-1:0] s);
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < 6; i++) begin
			if (i < SLOT_W) begin
				r[i] = s[i];
			end
		end
		return r;
	endfunction

	// 6-bit request index to a slot address
	function automatic logic [SLOT_W-1:0] slot_addr(input logic [5:0] s);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = 0; i < SLOT_W; i++) begin
			if (i < 6) begin
				r[i] = s[i];
			end
		end
		return r;
	endfunction

	function automatic logic slot_in_range(input logic [5:0] s);
		return int'(s) < SLOT_COUNT;
	endfunction

	// Ready count saturated to the 7-bit output field
	function automatic logic [6:0] sat_count(input logic [CNT_W-1:0] c);
		logic [CMP_W-1:0] w;
		w = CMP_W'(c);
		return (w > CMP_W'(127)) ? 7'd127 : w[6:0];
	endfunction

endpackage

### rtl/core/tofp_if.sv
// Request channel
interface tofp_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  opcode;
	logic [5:0]                  slot_index;
	logic [tofp_pkg::TIME_W-1:0] frame_time;
	logic [tofp_pkg::TIME_W-1:0] current_time;
	logic                        decoding_active;

	modport source (output valid, opcode, slot_index, frame_time, current_time,
		decoding_active, input ready);
	modport sink (input valid, opcode, slot_index, frame_time, current_time,
		decoding_active, output ready);
endinterface

// Result channel
interface tofp_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] result_slot;
	logic [1:0] status;
	logic [6:0] ready_count;

	modport source (output valid, result_slot, status, ready_count, input ready);
	modport sink (input valid, result_slot, status, ready_count, output ready);
endinterface

### rtl/core/tofp_ram.sv
// Simple dual-port RAM, one write and one registered read
module tofp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/timestamp_ordered_frame_pool_unit.sv
// Complete and no-op requests go straight to S_FIN; a claim scans the slots in order until one
// is free or stale or the pool ends, and a pick scans the whole pool, then both go to S_FIN.
// From S_FIN the result is staged into the output register once it is free of the last result.
// Throughput: one request at a time; the next is taken only after the result is staged.
// Reset (arst_n low, asynchronous) clears all done flags and sets min_ready_frames to 10;
// slot times are not cleared and are only used for slots marked done.
`include "timestamp_ordered_frame_pool_unit_macros.svh"

module timestamp_ordered_frame_pool_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	tofp_req_if.sink                       req,
	tofp_rsp_if.source                     rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tofp_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]                           state_q;
	logic [6:0]                           min_ready_q;
	logic [tofp_pkg::SLOT_COUNT-1:0]      done_q;

	// Latched request
	logic [1:0]                           op_q;
	logic [tofp_pkg::TIME_W-1:0]          now_q;
	logic                                 active_q;

	// Scan sequencer
	logic [tofp_pkg::CNT_W-1:0]           cnt_q;
	logic                                 vld_s1;
	logic [tofp_pkg::SLOT_W-1:0]          idx_s1;
	logic [tofp_pkg::CNT_W-1:0]           count_q;
	logic                                 found_q;
	logic [tofp_pkg::SLOT_W-1:0]          best_q;
	logic [tofp_pkg::TIME_W-1:0]          best_time_q;

	// Pending result and output register
	logic [5:0]                           res_slot_q;
	logic [1:0]                           res_status_q;
	logic [6:0]                           res_count_q;
	logic                                 out_valid_q;
	logic [5:0]                           out_slot_q;
	logic [1:0]                           out_status_q;
	logic [6:0]                           out_count_q;

	logic                                 req_take;
	logic                                 ram_we;
	logic [tofp_pkg::SLOT_W-1:0]          ram_waddr;
	logic [tofp_pkg::TIME_W-1:0]          rd_time;
	logic                                 lt_now;
	logic                                 lt_best;
	logic                                 done_s1;
	logic                                 claim_hit;
	logic                                 pick_hit;
	logic                                 scan_last;
	logic                                 out_free;
	logic                                 cfg_wr;
	logic [tofp_pkg::CMP_W-1:0]           count_ext;
	logic [tofp_pkg::CMP_W-1:0]           min_ext;

	// Handshakes
	assign req.ready = (state_q == S_IDLE);
	assign req_take  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.result_slot = out_slot_q;
	assign rsp.status      = out_status_q;
	assign rsp.ready_count = out_count_q;

	// Config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == tofp_pkg::REG_MIN_READY);
	assign prdata = (paddr[2] == tofp_pkg::REG_MIN_READY) ? {25'd0, min_ready_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ready_q <= tofp_pkg::MIN_READY_RESET;
		end else if (cfg_wr) begin
			min_ready_q <= pwdata[6:0];
		end
	end

	// Slot time store, written on complete, swept on claim and pick
	assign ram_waddr = tofp_pkg::slot_addr(req.slot_index);
	assign ram_we    = req_take && (req.opcode == tofp_pkg::OP_COMPLETE) &&
		tofp_pkg::slot_in_range(req.slot_index);

	tofp_ram #(
		.WIDTH (tofp_pkg::TIME_W),
		.DEPTH (tofp_pkg::SLOT_COUNT)
	) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.frame_time),
		.raddr (cnt_q[tofp_pkg::SLOT_W-1:0]),
		.rdata (rd_time)
	);

	// Shared compare unit on the slot just read
	assign lt_now    = rd_time < now_q;
	assign lt_best   = rd_time < best_time_q;
	assign done_s1   = done_q[idx_s1];
	assign claim_hit = vld_s1 && (op_q == tofp_pkg::OP_CLAIM) && (!done_s1 || lt_now);
	assign pick_hit  = vld_s1 && (op_q == tofp_pkg::OP_PICK) && done_s1 && !lt_now;
	assign scan_last = (cnt_q == tofp_pkg::SCAN_END) && !vld_s1;

	assign count_ext = tofp_pkg::CMP_W'(count_q);
	assign min_ext   = tofp_pkg::CMP_W'(min_ready_q);

	// Control: sequencer, done flags, scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			count_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				done_q[ram_waddr] <= 1'b1;
			end
			// result taken; a new one loaded in S_FIN keeps valid high
			if (out_valid_q && rsp.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						cnt_q   <= '0;
						vld_s1  <= 1'b0;
						count_q <= '0;
						found_q <= 1'b0;
						if (req.opcode == tofp_pkg::OP_CLAIM ||
							req.opcode == tofp_pkg::OP_PICK) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					// issue one read per cycle
					if (cnt_q != tofp_pkg::SCAN_END) begin
						cnt_q  <= cnt_q + 1'b1;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (claim_hit) begin
						done_q[idx_s1] <= 1'b0;
						state_q        <= S_FIN;
					end else if (scan_last) begin
						state_q <= S_FIN;
					end
					if (pick_hit) begin
						count_q <= count_q + 1'b1;
						if (!found_q || lt_best) begin
							found_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: request latch, best slot, result staging
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q     <= req.opcode;
			now_q    <= req.current_time;
			active_q <= req.decoding_active;
			if (req.opcode == tofp_pkg::OP_COMPLETE &&
				tofp_pkg::slot_in_range(req.slot_index)) begin
				res_slot_q   <= req.slot_index;
				res_status_q <= tofp_pkg::ST_OK;
			end else begin
				res_slot_q   <= 6'd0;
				res_status_q <= tofp_pkg::ST_WAIT;
			end
			res_count_q <= 7'd0;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= cnt_q[tofp_pkg::SLOT_W-1:0];
		end
		if (pick_hit && (!found_q || lt_best)) begin
			best_q      <= idx_s1;
			best_time_q <= rd_time;
		end
		// scan outcome
		if (state_q == S_SCAN) begin
			if (claim_hit) begin
				res_slot_q   <= tofp_pkg::slot_field(idx_s1);
				res_status_q <= tofp_pkg::ST_OK;
				res_count_q  <= 7'd0;
			end else if (scan_last && op_q == tofp_pkg::OP_CLAIM) begin
				res_slot_q   <= 6'd0;
				res_status_q <= tofp_pkg::ST_WAIT;
				res_count_q  <= 7'd0;
			end else if (scan_last) begin
				if (count_q == '0 && !active_q) begin
					res_slot_q   <= 6'd0;
					res_status_q <= tofp_pkg::ST_END;
					res_count_q  <= 7'd0;
				end else if (count_ext < min_ext || !found_q) begin
					res_slot_q   <= 6'd0;
					res_status_q <= tofp_pkg::ST_WAIT;
					res_count_q  <= tofp_pkg::sat_count(count_q);
				end else begin
					res_slot_q   <= tofp_pkg::slot_field(best_q);
					res_status_q <= tofp_pkg::ST_OK;
					res_count_q  <= tofp_pkg::sat_count(count_q);
				end
			end
		end
		if (state_q == S_FIN && out_free) begin
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
			out_count_q  <= res_count_q;
		end
	end

	`TOFP_ASSERT_NEXT(a_take_busy, clk, arst_n, req.valid && req.ready, state_q != S_IDLE,
		"request taken but sequencer idle")
	`TOFP_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= tofp_pkg::SCAN_END,
		"scan counter past pool")
	`TOFP_ASSERT(a_end_clean, clk, arst_n,
		!(rsp.valid && rsp.status == tofp_pkg::ST_END) ||
		(rsp.ready_count == 7'd0 && rsp.result_slot == 6'd0),
		"end result carries data")
	`TOFP_ASSERT(a_pick_enough, clk, arst_n,
		!(rsp.valid && rsp.status == tofp_pkg::ST_OK && rsp.ready_count != 7'd0) ||
		rsp.ready_count >= min_ready_q,
		"pick returned below threshold")

endmodule

### sim/timestamp_ordered_frame_pool_unit_test.sv
module timestamp_ordered_frame_pool_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic [tofp_pkg::PADDR_W-1:0] MIN_READY_ADDR =
		tofp_pkg::PADDR_W'(4 * int'(tofp_pkg::REG_MIN_READY));
	localparam int         PHASE_ITEMS = 190;

	typedef struct {
		logic [1:0]                  opcode;
		logic [5:0]                  slot_index;
		logic [tofp_pkg::TIME_W-1:0] frame_time;
		logic [tofp_pkg::TIME_W-1:0] current_time;
		logic                        decoding_active;
	} frame_req_t;

	typedef struct {
		logic [5:0] result_slot;
		logic [1:0] status;
		logic [6:0] ready_count;
	} frame_rsp_t;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [tofp_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	tofp_req_if req();
	tofp_rsp_if rsp();

	timestamp_ordered_frame_pool_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Mirror of the pool and its threshold
	logic                        done_mirror [tofp_pkg::SLOT_COUNT];
	logic [tofp_pkg::TIME_W-1:0] time_mirror [tofp_pkg::SLOT_COUNT];
	logic [6:0]                  min_ready_mirror;

	frame_req_t                  frame_requests [$];
	frame_rsp_t                  results_due [$];
	int                          mismatch_count;
	int                          req_gap;
	int                          sink_gap;
	bit                          src_calm;
	bit                          sink_calm;
	logic [tofp_pkg::TIME_W-1:0] play_time;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic flag_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Wait cycles for one request; calm stretches have none
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 31) == 0) begin
			calm = !calm;
		end
		return calm ? 0 : int'($urandom_range(0, 6));
	endfunction

	// Expected result of one request; updates the mirror
	function automatic frame_rsp_t pool_forecast(input frame_req_t r);
		frame_rsp_t res;
		int         ready_n;
		int         best;
		logic       found;
		res.result_slot = '0;
		res.status      = tofp_pkg::ST_WAIT;
		res.ready_count = '0;
		ready_n = 0;
		best    = 0;
		found   = 1'b0;
		case (r.opcode)
			tofp_pkg::OP_CLAIM: begin
				// lowest slot that is free or holds a stale frame
				for (int i = 0; i < tofp_pkg::SLOT_COUNT; i++) begin
					if (!found && (!done_mirror[i] || time_mirror[i] < r.current_time)) begin
						found           = 1'b1;
						done_mirror[i]  = 1'b0;
						res.result_slot = 6'(i);
						res.status      = tofp_pkg::ST_OK;
					end
				end
			end
			tofp_pkg::OP_COMPLETE: begin
				done_mirror[r.slot_index] = 1'b1;
				time_mirror[r.slot_index] = r.frame_time;
				res.result_slot = r.slot_index;
				res.status      = tofp_pkg::ST_OK;
			end
			tofp_pkg::OP_PICK: begin
				// earliest ready frame, lowest slot on a tie
				for (int i = 0; i < tofp_pkg::SLOT_COUNT; i++) begin
					if (done_mirror[i] && time_mirror[i] >= r.current_time) begin
						ready_n++;
						if (!found || time_mirror[i] < time_mirror[best]) begin
							found = 1'b1;
							best  = i;
						end
					end
				end
				if (ready_n == 0 && !r.decoding_active) begin
					res.status = tofp_pkg::ST_END;
				end else begin
					res.ready_count = 7'(ready_n);
					if (found && ready_n >= int'(min_ready_mirror)) begin
						res.status      = tofp_pkg::ST_OK;
						res.result_slot = 6'(best);
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic void push_req(input logic [1:0] op, input logic [5:0] idx,
		input logic [tofp_pkg::TIME_W-1:0] ft, input logic [tofp_pkg::TIME_W-1:0] now,
		input logic act);
		frame_req_t r;
		r.opcode          = op;
		r.slot_index      = idx;
		r.frame_time      = ft;
		r.current_time    = now;
		r.decoding_active = act;
		frame_requests.push_back(r);
	endfunction

	// Request driver
	always @(posedge clk) begin : req_driver
		frame_req_t held;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req_gap   <= 0;
		end else begin
			if (req.valid && req.ready) begin
				results_due.push_back(pool_forecast(held));
			end
			if (!req.valid || req.ready) begin
				if (req_gap != 0) begin
					req.valid <= 1'b0;
					req_gap   <= req_gap - 1;
				end else if (frame_requests.size() != 0) begin
					held = frame_requests.pop_front();
					req.opcode          <= held.opcode;
					req.slot_index      <= held.slot_index;
					req.frame_time      <= held.frame_time;
					req.current_time    <= held.current_time;
					req.decoding_active <= held.decoding_active;
					req.valid           <= 1'b1;
					req_gap             <= draw_wait(src_calm);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk) begin : rsp_monitor
		frame_rsp_t due;
		int         stall;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			sink_gap  <= 0;
		end else begin
			stall = sink_gap;
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result slot %0d status %0d count %0d",
						rsp.result_slot, rsp.status, rsp.ready_count));
				end else begin
					due = results_due.pop_front();
					if (rsp.result_slot !== due.result_slot || rsp.status !== due.status ||
						rsp.ready_count !== due.ready_count) begin
						flag_mismatch($sformatf("slot %0d/%0d status %0d/%0d count %0d/%0d",
							rsp.result_slot, due.result_slot, rsp.status, due.status,
							rsp.ready_count, due.ready_count));
					end
				end
				stall = draw_wait(sink_calm);
			end
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				sink_gap  <= stall - 1;
			end else begin
				rsp.ready <= 1'b1;
				sink_gap  <= 0;
			end
		end
	end

	// Wait until every request has gone through and every result came back
	task automatic drain();
		do begin
			@(negedge clk);
		end while (frame_requests.size() != 0 || req.valid || results_due.size() != 0);
	endtask

	// Write the threshold, then read it back
	task automatic set_min_ready(input logic [6:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MIN_READY_ADDR;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		min_ready_mirror = v;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== 32'(v)) begin
			flag_mismatch($sformatf("min_ready_frames read %0d, wrote %0d", prdata, v));
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly decode sequences, some pool fills, stale time jumps and noise
	task automatic random_phase(input int quota, input int win);
		int   made;
		int   n;
		int   kind;
		logic tie;
		made = 0;
		while (made < quota) begin
			kind = int'($urandom_range(0, 99));
			if (kind < 50) begin
				// claim/complete pairs, then pick the next frame
				n = int'($urandom_range(1, 6));
				repeat (n) begin
					push_req(tofp_pkg::OP_CLAIM, 6'($urandom), {$urandom, $urandom},
						play_time, 1'b1);
					push_req(tofp_pkg::OP_COMPLETE, 6'($urandom_range(0, win - 1)),
						play_time + 64'($urandom_range(0, 400)), play_time, 1'b1);
				end
				push_req(tofp_pkg::OP_PICK, 6'($urandom), {$urandom, $urandom}, play_time,
					$urandom_range(0, 9) != 0);
				play_time += 64'($urandom_range(0, 60));
				made += 2 * n + 1;
			end else if (kind < 62) begin
				// fill the window, then claim and pick
				tie = 1'($urandom);
				for (int s = 0; s < win; s++) begin
					push_req(tofp_pkg::OP_COMPLETE, 6'(s),
						play_time + (tie ? 64'd0 : 64'($urandom_range(0, 300))), play_time, 1'b1);
				end
				push_req(tofp_pkg::OP_CLAIM, 6'($urandom), {$urandom, $urandom},
					play_time, 1'b1);
				push_req(tofp_pkg::OP_PICK, 6'($urandom), {$urandom, $urandom},
					play_time, 1'b1);
				made += win + 2;
			end else if (kind < 77) begin
				// playback runs ahead of the decoded frames
				play_time += 64'($urandom_range(0, 1000));
				push_req(tofp_pkg::OP_PICK, 6'($urandom), {$urandom, $urandom},
					play_time, 1'($urandom));
				push_req(tofp_pkg::OP_CLAIM, 6'($urandom), {$urandom, $urandom},
					play_time, 1'b1);
				made += 2;
			end else if (kind < 90) begin
				push_req(2'($urandom), 6'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
					1'($urandom));
				made += 1;
			end else if (kind < 95) begin
				play_time = {$urandom, $urandom};
			end else begin
				play_time = {32'hFFFF_FFFF, $urandom};
			end
		end
	endtask

	initial begin : stimulus
		arst_n              = 1'b0;
		req.valid           = 1'b0;
		req.opcode          = tofp_pkg::OP_CLAIM;
		req.slot_index      = '0;
		req.frame_time      = '0;
		req.current_time    = '0;
		req.decoding_active = 1'b0;
		rsp.ready           = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		mismatch_count      = 0;
		src_calm            = 1'b0;
		sink_calm           = 1'b0;
		play_time           = 64'd1000;
		for (int i = 0; i < tofp_pkg::SLOT_COUNT; i++) begin
			done_mirror[i] = 1'b0;
			time_mirror[i] = '0;
		end
		min_ready_mirror = tofp_pkg::MIN_READY_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty pool: end of stream, then wait; no-op with all ones
		push_req(tofp_pkg::OP_PICK, 6'd0, '0, '0, 1'b0);
		push_req(tofp_pkg::OP_PICK, 6'd0, '0, '0, 1'b1);
		push_req(OP_NOP, '1, '1, '1, 1'b1);
		push_req(tofp_pkg::OP_CLAIM, '1, '1, '0, 1'b1);
		push_req(tofp_pkg::OP_COMPLETE, 6'd63, '1, '0, 1'b0);
		push_req(tofp_pkg::OP_COMPLETE, 6'd0, '0, '1, 1'b1);
		// slot 0 done at time 0 is not stale at now 0, but is at now 1
		push_req(tofp_pkg::OP_CLAIM, 6'd0, '0, '0, 1'b0);
		push_req(tofp_pkg::OP_CLAIM, 6'd0, '0, 64'd1, 1'b1);
		push_req(tofp_pkg::OP_COMPLETE, 6'd5, 64'd100, '0, 1'b1);
		push_req(tofp_pkg::OP_COMPLETE, 6'd6, 64'd100, '0, 1'b1);
		// below threshold: wait with a count
		push_req(tofp_pkg::OP_PICK, 6'd0, '0, '0, 1'b1);
		drain();

		set_min_ready(7'd1);
		// tie on time, then an all-ones time, then end and wait
		push_req(tofp_pkg::OP_PICK, 6'd0, '0, 64'd50, 1'b1);
		push_req(tofp_pkg::OP_PICK, 6'd0, '0, '1, 1'b0);
		push_req(tofp_pkg::OP_COMPLETE, 6'd63, '0, '0, 1'b1);
		push_req(tofp_pkg::OP_PICK, 6'd0, '0, '1, 1'b0);
		push_req(tofp_pkg::OP_PICK, 6'd0, '0, '1, 1'b1);
		random_phase(PHASE_ITEMS, 16);
		drain();

		set_min_ready(7'd0);
		push_req(tofp_pkg::OP_PICK, 6'd0, '0, '1, 1'b1);
		random_phase(PHASE_ITEMS, 8);
		drain();

		set_min_ready(7'd64);
		random_phase(PHASE_ITEMS, 64);
		drain();

		repeat (2) begin
			set_min_ready(7'($urandom_range(2, 63)));
			random_phase(PHASE_ITEMS, 32);
			drain();
		end

		set_min_ready(tofp_pkg::MIN_READY_RESET);
		random_phase(PHASE_ITEMS, 64);
		drain();

		repeat (tofp_pkg::SLOT_COUNT + 8) @(posedge clk);
		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

### timestamp_ordered_frame_pool_unit.f
+incdir+rtl/core
rtl/core/tofp_pkg.sv
rtl/core/tofp_if.sv
rtl/core/tofp_ram.sv
rtl/core/timestamp_ordered_frame_pool_unit.sv
sim/timestamp_ordered_frame_pool_unit_test.sv
